### sv/charger_led_blink_sequencer_top_macros.svh
// Assertion helpers for the LED blink sequencer.
// All checks are clocked on clk and switched off while rst_n is low.
`ifndef CHARGER_LED_BLINK_SEQUENCER_TOP_MACROS_SVH
`define CHARGER_LED_BLINK_SEQUENCER_TOP_MACROS_SVH

// Same-cycle implication
`define CLBS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define CLBS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/clbs_pkg.sv
package clbs_pkg;

  // Battery class codes
  typedef enum logic [1:0] {
    CLS_OTHER    = 2'd0,
    CLS_CHARGING = 2'd1,
    CLS_FULL     = 2'd2,
    CLS_ERROR    = 2'd3
  } batt_class_t;

  // Configuration register indexes
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_ADDR_W-1:0] REG_CHARGE_DISPLAY_EN = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_CHARGE_BLINK_LIM  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_ERROR_BLINK_LIM   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_INTRO_LIM         = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_ROTATE_ON_LIM     = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_ROTATE_OFF_LIM    = 3'd5;

  // Register reset values
  localparam logic [7:0] RST_CHARGE_BLINK_LIM = 8'd100;
  localparam logic [7:0] RST_ERROR_BLINK_LIM  = 8'd10;
  localparam logic [7:0] RST_INTRO_LIM        = 8'd100;
  localparam logic [7:0] RST_ROTATE_ON_LIM    = 8'd50;
  localparam logic [7:0] RST_ROTATE_OFF_LIM   = 8'd200;

  localparam int unsigned NUM_LEDS = 4;

endpackage

### sv/charger_led_blink_sequencer_top.sv
// Battery LED blink sequencer.
// Each accepted input word gives a registered result word.
// One word per cycle unless stalled; the tick update is one pass of
// compare and increment logic ahead of the state and result registers.
// Reset (rst_n low, synchronous): LEDs off, counters and phases cleared,
// intro pending, registers back to their defaults.
module charger_led_blink_sequencer_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_charging_mode,
  input  logic                                in_output_normal,
  input  logic [1:0]                          in_battery0_class,
  input  logic [1:0]                          in_battery1_class,
  input  logic [1:0]                          in_battery2_class,
  input  logic [1:0]                          in_battery3_class,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [3:0]                          out_led_lit,
  input  logic                                cfg_we,
  input  logic [clbs_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [clbs_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  `include "charger_led_blink_sequencer_top_macros.svh"

  // Configuration registers
  logic       chg_en_r;
  logic [7:0] chg_lim_r;
  logic [7:0] err_lim_r;
  logic [7:0] intro_lim_r;
  logic [7:0] rot_on_lim_r;
  logic [7:0] rot_off_lim_r;

  // Sequencer state
  logic [3:0] led_latch_r,      led_latch_nxt;
  logic       charge_phase_r,   charge_phase_nxt;
  logic [7:0] charge_ticks_r,   charge_ticks_nxt;
  logic       error_phase_r,    error_phase_nxt;
  logic [7:0] error_ticks_r,    error_ticks_nxt;
  logic [7:0] mode_ticks_r,     mode_ticks_nxt;
  logic       intro_done_r,     intro_done_nxt;
  logic       rotate_started_r, rotate_started_nxt;
  logic [1:0] rotate_index_r,   rotate_index_nxt;
  logic       rotate_lit_r,     rotate_lit_nxt;
  logic       out_valid_r;

  logic [1:0] cls [clbs_pkg::NUM_LEDS];
  logic [7:0] chg_inc;
  logic [7:0] err_inc;
  logic [7:0] mode_inc;
  logic       in_acc;

  assign cls[0] = in_battery0_class;
  assign cls[1] = in_battery1_class;
  assign cls[2] = in_battery2_class;
  assign cls[3] = in_battery3_class;

  // Result word is the latch itself; it only moves when a word is taken
  assign in_stall    = out_valid_r && out_stall;
  assign in_acc      = in_valid && !in_stall;
  assign out_valid   = out_valid_r;
  assign out_led_lit = led_latch_r;

  assign chg_inc  = charge_ticks_r + 8'd1;
  assign err_inc  = error_ticks_r + 8'd1;
  assign mode_inc = mode_ticks_r + 8'd1;

  // Tick update
  always_comb begin
    led_latch_nxt      = led_latch_r;
    charge_phase_nxt   = charge_phase_r;
    charge_ticks_nxt   = charge_ticks_r;
    error_phase_nxt    = error_phase_r;
    error_ticks_nxt    = error_ticks_r;
    mode_ticks_nxt     = mode_ticks_r;
    intro_done_nxt     = intro_done_r;
    rotate_started_nxt = rotate_started_r;
    rotate_index_nxt   = rotate_index_r;
    rotate_lit_nxt     = rotate_lit_r;

    if (in_charging_mode) begin
      // slow blink for charging and full, full stays lit in the dark phase
      if (chg_en_r) begin
        for (int n = 0; n < clbs_pkg::NUM_LEDS; n++) begin
          if (!charge_phase_r) begin
            if (cls[n] == clbs_pkg::CLS_CHARGING || cls[n] == clbs_pkg::CLS_FULL) begin
              led_latch_nxt[n] = 1'b1;
            end
          end else if (cls[n] == clbs_pkg::CLS_CHARGING) begin
            led_latch_nxt[n] = 1'b0;
          end
        end
        if (chg_inc > chg_lim_r) begin
          charge_ticks_nxt = '0;
          charge_phase_nxt = !charge_phase_r;
        end else begin
          charge_ticks_nxt = chg_inc;
        end
      end
      // fast blink for errors
      for (int n = 0; n < clbs_pkg::NUM_LEDS; n++) begin
        if (cls[n] == clbs_pkg::CLS_ERROR) begin
          led_latch_nxt[n] = !error_phase_r;
        end
      end
      if (err_inc >= err_lim_r) begin
        error_ticks_nxt = '0;
        error_phase_nxt = !error_phase_r;
      end else begin
        error_ticks_nxt = err_inc;
      end
    end else begin
      mode_ticks_nxt = mode_inc;
      if (!intro_done_r) begin
        // all-on intro
        if (mode_inc > intro_lim_r) begin
          led_latch_nxt  = '0;
          intro_done_nxt = 1'b1;
          mode_ticks_nxt = '0;
        end else begin
          led_latch_nxt = '1;
        end
      end else if (in_output_normal) begin
        // single rotating LED
        if (!rotate_started_r) begin
          rotate_started_nxt = 1'b1;
          rotate_index_nxt   = '0;
          rotate_lit_nxt     = 1'b1;
          led_latch_nxt[0]   = 1'b1;
        end else if (rotate_lit_r) begin
          if (mode_inc > rot_on_lim_r) begin
            led_latch_nxt[rotate_index_r] = 1'b0;
            rotate_index_nxt = rotate_index_r + 2'd1;
            mode_ticks_nxt   = '0;
            rotate_lit_nxt   = 1'b0;
          end
        end else if (mode_inc > rot_off_lim_r) begin
          led_latch_nxt[rotate_index_r] = 1'b1;
          rotate_lit_nxt = 1'b1;
          mode_ticks_nxt = '0;
        end
      end
    end
  end

  // State, result valid and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chg_en_r         <= 1'b1;
      chg_lim_r        <= clbs_pkg::RST_CHARGE_BLINK_LIM;
      err_lim_r        <= clbs_pkg::RST_ERROR_BLINK_LIM;
      intro_lim_r      <= clbs_pkg::RST_INTRO_LIM;
      rot_on_lim_r     <= clbs_pkg::RST_ROTATE_ON_LIM;
      rot_off_lim_r    <= clbs_pkg::RST_ROTATE_OFF_LIM;
      led_latch_r      <= '0;
      charge_phase_r   <= 1'b0;
      charge_ticks_r   <= '0;
      error_phase_r    <= 1'b0;
      error_ticks_r    <= '0;
      mode_ticks_r     <= '0;
      intro_done_r     <= 1'b0;
      rotate_started_r <= 1'b0;
      rotate_index_r   <= '0;
      rotate_lit_r     <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          clbs_pkg::REG_CHARGE_DISPLAY_EN: chg_en_r      <= cfg_wdata[0];
          clbs_pkg::REG_CHARGE_BLINK_LIM:  chg_lim_r     <= cfg_wdata;
          clbs_pkg::REG_ERROR_BLINK_LIM:   err_lim_r     <= cfg_wdata;
          clbs_pkg::REG_INTRO_LIM:         intro_lim_r   <= cfg_wdata;
          clbs_pkg::REG_ROTATE_ON_LIM:     rot_on_lim_r  <= cfg_wdata;
          clbs_pkg::REG_ROTATE_OFF_LIM:    rot_off_lim_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_acc) begin
        led_latch_r      <= led_latch_nxt;
        charge_phase_r   <= charge_phase_nxt;
        charge_ticks_r   <= charge_ticks_nxt;
        error_phase_r    <= error_phase_nxt;
        error_ticks_r    <= error_ticks_nxt;
        mode_ticks_r     <= mode_ticks_nxt;
        intro_done_r     <= intro_done_nxt;
        rotate_started_r <= rotate_started_nxt;
        rotate_index_r   <= rotate_index_nxt;
        rotate_lit_r     <= rotate_lit_nxt;
        out_valid_r      <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r      <= 1'b0;
      end
    end
  end

  // Checks
  `CLBS_ASSERT_NEXT(a_result_follows, in_acc, out_valid_r, "no result after accepted word")
  `CLBS_ASSERT_NOW(a_no_rotate_in_intro, !intro_done_r, !rotate_started_r, "rotation before intro end")
  `CLBS_ASSERT_NEXT(a_mode_held_charging, in_acc && in_charging_mode, $stable(mode_ticks_r), "mode counter moved while charging")
  `CLBS_ASSERT_NEXT(a_blink_held_idle, in_acc && !in_charging_mode, $stable(error_ticks_r) && $stable(charge_ticks_r), "blink counters moved outside charging")
  `CLBS_ASSERT_NEXT(a_rotate_one_led, in_acc && !in_charging_mode && intro_done_r, $countones(led_latch_r ^ $past(led_latch_r)) <= 1, "rotation changed more than one LED")

endmodule

### tb/sv/charger_led_blink_sequencer_top_tb.sv
module charger_led_blink_sequencer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Register index past the end of the list; writes to it are dropped
  localparam logic [clbs_pkg::CFG_ADDR_W-1:0] REG_UNUSED = 3'd6;
  localparam int IDLE_LIMIT = 3000;
  localparam int HOLD_CYCLES = 60;

  typedef struct packed {
    logic                  charging;
    logic                  normal;
    clbs_pkg::batt_class_t b3;
    clbs_pkg::batt_class_t b2;
    clbs_pkg::batt_class_t b1;
    clbs_pkg::batt_class_t b0;
  } tick_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic                            in_charging_mode = 1'b0;
  logic                            in_output_normal = 1'b0;
  logic [1:0]                      in_battery0_class = '0;
  logic [1:0]                      in_battery1_class = '0;
  logic [1:0]                      in_battery2_class = '0;
  logic [1:0]                      in_battery3_class = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [3:0]                      out_led_lit;
  logic                            cfg_we = 1'b0;
  logic [clbs_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [clbs_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  // Words waiting to be offered, and LED patterns expected back
  tick_t      tick_queue [$];
  logic [3:0] led_expect [$];

  int   err_cnt = 0;
  int   idle_cycles = 0;
  int   hold_left = 0;
  logic calm = 1'b0;
  logic hold_go = 1'b0;
  logic hold_done = 1'b0;

  // Register mirror
  logic       show_charge = 1'b1;
  logic [7:0] chg_limit = clbs_pkg::RST_CHARGE_BLINK_LIM;
  logic [7:0] err_limit = clbs_pkg::RST_ERROR_BLINK_LIM;
  logic [7:0] intro_limit = clbs_pkg::RST_INTRO_LIM;
  logic [7:0] on_limit = clbs_pkg::RST_ROTATE_ON_LIM;
  logic [7:0] off_limit = clbs_pkg::RST_ROTATE_OFF_LIM;

  // Blink and rotation state of the predictor
  logic [3:0] lit_leds = '0;
  logic       chg_phase = 1'b0;
  logic [7:0] chg_ticks = '0;
  logic       err_phase = 1'b0;
  logic [7:0] err_ticks = '0;
  logic [7:0] mode_ticks = '0;
  logic       intro_done = 1'b0;
  logic       rot_started = 1'b0;
  logic [1:0] rot_idx = '0;
  logic       rot_lit = 1'b0;

  charger_led_blink_sequencer_top DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_charging_mode  (in_charging_mode),
    .in_output_normal  (in_output_normal),
    .in_battery0_class (in_battery0_class),
    .in_battery1_class (in_battery1_class),
    .in_battery2_class (in_battery2_class),
    .in_battery3_class (in_battery3_class),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_led_lit       (out_led_lit),
    .cfg_we            (cfg_we),
    .cfg_addr          (cfg_addr),
    .cfg_wdata         (cfg_wdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Advance the LED state by one tick and return the latch afterwards
  function automatic logic [3:0] advance_leds(input tick_t t);
    clbs_pkg::batt_class_t cls [4];
    cls[0] = t.b0;
    cls[1] = t.b1;
    cls[2] = t.b2;
    cls[3] = t.b3;
    if (t.charging) begin
      if (show_charge) begin
        for (int n = 0; n < 4; n++) begin
          if (!chg_phase) begin
            if (cls[n] == clbs_pkg::CLS_CHARGING || cls[n] == clbs_pkg::CLS_FULL)
              lit_leds[n] = 1'b1;
          end else if (cls[n] == clbs_pkg::CLS_CHARGING) begin
            lit_leds[n] = 1'b0;
          end
        end
        chg_ticks = chg_ticks + 8'd1;
        if (chg_ticks > chg_limit) begin
          chg_ticks = '0;
          chg_phase = ~chg_phase;
        end
      end
      // error LEDs follow the fast phase regardless of the display enable
      for (int n = 0; n < 4; n++) begin
        if (cls[n] == clbs_pkg::CLS_ERROR) lit_leds[n] = ~err_phase;
      end
      err_ticks = err_ticks + 8'd1;
      if (err_ticks >= err_limit) begin
        err_ticks = '0;
        err_phase = ~err_phase;
      end
    end else begin
      mode_ticks = mode_ticks + 8'd1;
      if (!intro_done) begin
        if (mode_ticks > intro_limit) begin
          lit_leds = '0;
          intro_done = 1'b1;
          mode_ticks = '0;
        end else begin
          lit_leds = 4'hF;
        end
      end else if (t.normal) begin
        if (!rot_started) begin
          rot_started = 1'b1;
          rot_idx = '0;
          rot_lit = 1'b1;
          lit_leds[0] = 1'b1;
        end else if (rot_lit) begin
          if (mode_ticks > on_limit) begin
            lit_leds[rot_idx] = 1'b0;
            rot_idx = rot_idx + 2'd1;
            mode_ticks = '0;
            rot_lit = 1'b0;
          end
        end else if (mode_ticks > off_limit) begin
          lit_leds[rot_idx] = 1'b1;
          rot_lit = 1'b1;
          mode_ticks = '0;
        end
      end
    end
    return lit_leds;
  endfunction

  function automatic tick_t mk_tick(input logic chg, input logic norm,
                                    input clbs_pkg::batt_class_t c0,
                                    input clbs_pkg::batt_class_t c1,
                                    input clbs_pkg::batt_class_t c2,
                                    input clbs_pkg::batt_class_t c3);
    tick_t t;
    t.charging = chg;
    t.normal = norm;
    t.b0 = c0;
    t.b1 = c1;
    t.b2 = c2;
    t.b3 = c3;
    return t;
  endfunction

  // Driver: offer queued words, predict each one as it is taken
  always @(posedge clk) begin : drive
    tick_t seen;
    tick_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        seen.charging = in_charging_mode;
        seen.normal = in_output_normal;
        seen.b0 = clbs_pkg::batt_class_t'(in_battery0_class);
        seen.b1 = clbs_pkg::batt_class_t'(in_battery1_class);
        seen.b2 = clbs_pkg::batt_class_t'(in_battery2_class);
        seen.b3 = clbs_pkg::batt_class_t'(in_battery3_class);
        led_expect.push_back(advance_leds(seen));
      end
      if (!in_valid || !in_stall) begin
        if (tick_queue.size() != 0 && (calm || $urandom_range(99) >= 21)) begin
          nxt = tick_queue.pop_front();
          in_valid <= 1'b1;
          in_charging_mode <= nxt.charging;
          in_output_normal <= nxt.normal;
          in_battery0_class <= nxt.b0;
          in_battery1_class <= nxt.b1;
          in_battery2_class <= nxt.b2;
          in_battery3_class <= nxt.b3;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check result words, drive the stall with one long hold-off
  always @(posedge clk) begin : monitor
    logic [3:0] want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (led_expect.size() == 0) begin
          $error("out_led_lit: no word expected, actual %h", out_led_lit);
          err_cnt = err_cnt + 1;
        end else begin
          want = led_expect.pop_front();
          if (out_led_lit !== want) begin
            $error("out_led_lit: expected %h, actual %h", want, out_led_lit);
            err_cnt = err_cnt + 1;
          end
        end
      end
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (hold_go && !hold_done) begin
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 21);
      end
    end
  end

  // Watchdog on cycles where neither channel moves a word
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic wait_drained();
    while (tick_queue.size() != 0 || in_valid || led_expect.size() != 0)
      @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(input logic [clbs_pkg::CFG_ADDR_W-1:0] idx,
                           input logic [7:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    case (idx)
      clbs_pkg::REG_CHARGE_DISPLAY_EN: show_charge = val[0];
      clbs_pkg::REG_CHARGE_BLINK_LIM:  chg_limit = val;
      clbs_pkg::REG_ERROR_BLINK_LIM:   err_limit = val;
      clbs_pkg::REG_INTRO_LIM:         intro_limit = val;
      clbs_pkg::REG_ROTATE_ON_LIM:     on_limit = val;
      clbs_pkg::REG_ROTATE_OFF_LIM:    off_limit = val;
      default: ;
    endcase
  endtask

  // Runs of charging and discharging ticks, with odd words of the other mode
  task automatic queue_random_ticks(input int count);
    tick_t t;
    int    run_left;
    logic  chg;
    run_left = 0;
    chg = 1'b0;
    for (int k = 0; k < count; k++) begin
      if (run_left == 0) begin
        run_left = $urandom_range(80, 1);
        chg = 1'($urandom_range(1));
      end
      run_left--;
      t.charging = ($urandom_range(19) == 0) ? ~chg : chg;
      t.normal = ($urandom_range(99) < 85);
      t.b0 = clbs_pkg::batt_class_t'($urandom_range(3));
      t.b1 = clbs_pkg::batt_class_t'($urandom_range(3));
      t.b2 = clbs_pkg::batt_class_t'($urandom_range(3));
      t.b3 = clbs_pkg::batt_class_t'($urandom_range(3));
      tick_queue.push_back(t);
    end
  endtask

  // Program all six registers once idle, then queue a random run
  task automatic run_phase(input logic en, input logic [7:0] cbl, input logic [7:0] ebl,
                           input logic [7:0] intro, input logic [7:0] on_l,
                           input logic [7:0] off_l, input int count);
    wait_drained();
    // upper bits of the enable word are don't-care
    write_reg(clbs_pkg::REG_CHARGE_DISPLAY_EN, {7'($urandom_range(127)), en});
    write_reg(clbs_pkg::REG_CHARGE_BLINK_LIM, cbl);
    write_reg(clbs_pkg::REG_ERROR_BLINK_LIM, ebl);
    write_reg(clbs_pkg::REG_INTRO_LIM, intro);
    write_reg(clbs_pkg::REG_ROTATE_ON_LIM, on_l);
    write_reg(clbs_pkg::REG_ROTATE_OFF_LIM, off_l);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    queue_random_ticks(count);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: every class in both modes, with reset register values
    tick_queue.push_back(mk_tick(1'b1, 1'b1, clbs_pkg::CLS_OTHER, clbs_pkg::CLS_OTHER,
                                 clbs_pkg::CLS_OTHER, clbs_pkg::CLS_OTHER));
    tick_queue.push_back(mk_tick(1'b1, 1'b0, clbs_pkg::CLS_CHARGING, clbs_pkg::CLS_CHARGING,
                                 clbs_pkg::CLS_CHARGING, clbs_pkg::CLS_CHARGING));
    tick_queue.push_back(mk_tick(1'b1, 1'b1, clbs_pkg::CLS_FULL, clbs_pkg::CLS_FULL,
                                 clbs_pkg::CLS_FULL, clbs_pkg::CLS_FULL));
    tick_queue.push_back(mk_tick(1'b1, 1'b0, clbs_pkg::CLS_ERROR, clbs_pkg::CLS_ERROR,
                                 clbs_pkg::CLS_ERROR, clbs_pkg::CLS_ERROR));
    tick_queue.push_back(mk_tick(1'b1, 1'b1, clbs_pkg::CLS_OTHER, clbs_pkg::CLS_CHARGING,
                                 clbs_pkg::CLS_FULL, clbs_pkg::CLS_ERROR));
    tick_queue.push_back(mk_tick(1'b1, 1'b1, clbs_pkg::CLS_ERROR, clbs_pkg::CLS_FULL,
                                 clbs_pkg::CLS_CHARGING, clbs_pkg::CLS_OTHER));
    // classes are ignored outside charging; the intro lights everything
    tick_queue.push_back(mk_tick(1'b0, 1'b0, clbs_pkg::CLS_ERROR, clbs_pkg::CLS_ERROR,
                                 clbs_pkg::CLS_ERROR, clbs_pkg::CLS_ERROR));
    tick_queue.push_back(mk_tick(1'b0, 1'b1, clbs_pkg::CLS_CHARGING, clbs_pkg::CLS_FULL,
                                 clbs_pkg::CLS_ERROR, clbs_pkg::CLS_OTHER));
    tick_queue.push_back(mk_tick(1'b1, 1'b0, clbs_pkg::CLS_ERROR, clbs_pkg::CLS_OTHER,
                                 clbs_pkg::CLS_ERROR, clbs_pkg::CLS_OTHER));
    tick_queue.push_back(mk_tick(1'b0, 1'b1, clbs_pkg::CLS_ERROR, clbs_pkg::CLS_ERROR,
                                 clbs_pkg::CLS_ERROR, clbs_pkg::CLS_ERROR));
    tick_queue.push_back(mk_tick(1'b1, 1'b1, clbs_pkg::CLS_FULL, clbs_pkg::CLS_ERROR,
                                 clbs_pkg::CLS_OTHER, clbs_pkg::CLS_CHARGING));
    tick_queue.push_back(mk_tick(1'b0, 1'b0, clbs_pkg::CLS_OTHER, clbs_pkg::CLS_OTHER,
                                 clbs_pkg::CLS_OTHER, clbs_pkg::CLS_OTHER));

    // Reset values, with the receiver holding off while words keep coming
    queue_random_ticks(250);
    repeat (20) @(negedge clk);
    hold_go = 1'b1;

    // Zero limits: error phase toggles every tick
    run_phase(1'b1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 230);
    // Display off, limits at the top of their range
    run_phase(1'b0, 8'd255, 8'd255, 8'd254, 8'd254, 8'd254, 230);

    // Limits past their stated range, plus a write to an unused index
    wait_drained();
    write_reg(REG_UNUSED, 8'd3);
    run_phase(1'b1, 8'd255, 8'd1, 8'd255, 8'd255, 8'd255, 200);

    // Short blink and rotation times, no idling on either side
    wait_drained();
    calm = 1'b1;
    run_phase(1'b1, 8'd3, 8'd2, 8'd5, 8'd3, 8'd4, 250);
    wait_drained();
    calm = 1'b0;

    // Random register settings
    repeat (2) begin
      run_phase(1'($urandom_range(1)), 8'($urandom_range(255)), 8'($urandom_range(255)),
                8'($urandom_range(255)), 8'($urandom_range(40)),
                8'($urandom_range(40)), 240);
    end

    wait_drained();
    if (err_cnt == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
